// ===== sv/bdq_pkg.sv =====
package bdq_pkg;

  // fixed field widths
  localparam int REQ_W   = 3;
  localparam int WORD_W  = 32;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 4;

  // default number of slots
  localparam int DEPTH_DEF = 8;

  // request codes
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_REAR  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_REAR   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SEARCH     = 3'd4;
  localparam logic [REQ_W-1:0] REQ_COUNT      = 3'd5;
  localparam logic [REQ_W-1:0] REQ_READ_ALL   = 3'd6;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic              take;
    logic              push_front;
    logic              push_rear;
    logic              pop_front;
    logic              pop_rear;
    logic              scan_read;
    logic              scan_step;
    logic              emit_single;
    logic              emit_entry;
    logic [STAT_W-1:0] emit_status;
  } bdq_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             empty;
    logic             head_zero;
    logic             rear_full;
    logic             scan_last;
    logic             out_free;
  } bdq_sts_t;

endpackage

// ===== sv/bdq_req_if.sv =====
interface bdq_req_if import bdq_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink (input valid, input req_type, input value, output ready);
endinterface

// ===== sv/bdq_rsp_if.sv =====
interface bdq_rsp_if import bdq_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [WORD_W-1:0] data;
  logic [CNT_W-1:0]         hits;
  logic [CNT_W-1:0]         occupancy;
  logic                     last;

  modport source (output valid, output status, output data, output hits,
                  output occupancy, output last, input ready);
  modport sink (input valid, input status, input data, input hits,
                input occupancy, input last, output ready);
endinterface

// ===== sv/bdq_ctrl.sv =====
module bdq_ctrl import bdq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  bdq_sts_t sts,
  output bdq_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_ADDR = 3'd2;
  localparam logic [2:0] S_DATA = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // next state and command decode
  always_comb begin
    cmd        = '0;
    state_next = state;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.take   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          unique case (sts.req_type)
            REQ_PUSH_FRONT: begin
              cmd.emit_single = 1'b1;
              state_next      = S_IDLE;
              if (sts.empty || !sts.head_zero) cmd.push_front = 1'b1;
              else cmd.emit_status = ST_FULL;
            end
            REQ_PUSH_REAR: begin
              cmd.emit_single = 1'b1;
              state_next      = S_IDLE;
              if (sts.rear_full) cmd.emit_status = ST_FULL;
              else cmd.push_rear = 1'b1;
            end
            REQ_POP_FRONT: begin
              cmd.emit_single = 1'b1;
              state_next      = S_IDLE;
              if (sts.empty) cmd.emit_status = ST_EMPTY;
              else cmd.pop_front = 1'b1;
            end
            REQ_POP_REAR: begin
              cmd.emit_single = 1'b1;
              state_next      = S_IDLE;
              if (sts.empty) cmd.emit_status = ST_EMPTY;
              else cmd.pop_rear = 1'b1;
            end
            REQ_SEARCH, REQ_READ_ALL: begin
              if (sts.empty) begin
                cmd.emit_single = 1'b1;
                cmd.emit_status = ST_EMPTY;
                state_next      = S_IDLE;
              end else begin
                state_next = S_ADDR;
              end
            end
            default: begin
              // count and the unused code report the occupancy only
              cmd.emit_single = 1'b1;
              state_next      = S_IDLE;
            end
          endcase
        end
      end
      S_ADDR: begin
        cmd.scan_read = 1'b1;
        state_next    = S_DATA;
      end
      S_DATA: begin
        if (sts.req_type == REQ_SEARCH) begin
          cmd.scan_step = 1'b1;
          state_next    = sts.scan_last ? S_DONE : S_ADDR;
        end else if (sts.out_free) begin
          cmd.scan_step  = 1'b1;
          cmd.emit_entry = 1'b1;
          state_next     = sts.scan_last ? S_IDLE : S_ADDR;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit_single = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

// ===== sv/bdq_dp.sv =====
module bdq_dp import bdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [REQ_W-1:0]         req_type,
  input  logic signed [WORD_W-1:0] req_value,
  output logic                     rsp_valid,
  input  logic                     rsp_ready,
  output logic [STAT_W-1:0]        rsp_status,
  output logic signed [WORD_W-1:0] rsp_data,
  output logic [CNT_W-1:0]         rsp_hits,
  output logic [CNT_W-1:0]         rsp_occupancy,
  output logic                     rsp_last,
  input  bdq_cmd_t                 cmd,
  output bdq_sts_t                 sts
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data;

  logic [REQ_W-1:0]  req_reg;
  logic [WORD_W-1:0] val_reg;
  logic [IW-1:0]     head;
  logic [IW-1:0]     head_next;
  logic [CW-1:0]     fill;
  logic [CW-1:0]     fill_next;
  logic [IW-1:0]     idx;
  logic [CW-1:0]     hits;

  logic [CW:0]       rear_sum;
  logic              empty;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [IW-1:0]     rd_addr;
  logic              scan_last;
  logic              match;

  // position just past the tail and scan address
  assign rear_sum  = (CW+1)'(head) + (CW+1)'(fill);
  assign empty     = (fill == '0);
  assign rd_addr   = head + idx;
  assign scan_last = ((CW'(idx) + CW'(1)) == fill);
  assign match     = (rd_data == val_reg);

  // status to the controller
  assign sts.req_type  = req_reg;
  assign sts.empty     = empty;
  assign sts.head_zero = (head == '0);
  assign sts.rear_full = (rear_sum >= (CW+1)'(DEPTH));
  assign sts.scan_last = scan_last;
  assign sts.out_free  = !rsp_valid || rsp_ready;

  // head and fill update for inserts and deletes
  always_comb begin
    head_next = head;
    fill_next = fill;
    wr_en     = 1'b0;
    wr_addr   = rear_sum[IW-1:0];
    if (cmd.push_front) begin
      wr_en = 1'b1;
      if (empty) begin
        head_next = '0;
        fill_next = CW'(1);
        wr_addr   = '0;
      end else begin
        head_next = head - IW'(1);
        fill_next = fill + CW'(1);
        wr_addr   = head - IW'(1);
      end
    end else if (cmd.push_rear) begin
      wr_en     = 1'b1;
      fill_next = fill + CW'(1);
    end else if (cmd.pop_front || cmd.pop_rear) begin
      fill_next = fill - CW'(1);
      if (fill == CW'(1)) head_next = '0;
      else if (cmd.pop_front) head_next = head + IW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
      idx  <= '0;
      hits <= '0;
    end else begin
      head <= head_next;
      fill <= fill_next;
      if (cmd.take) begin
        idx  <= '0;
        hits <= '0;
      end else if (cmd.scan_step) begin
        idx <= idx + IW'(1);
        if (req_reg == REQ_SEARCH && match) hits <= hits + CW'(1);
      end
    end
  end

  // request holding register
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_reg <= req_type;
      val_reg <= req_value;
    end
  end

  // slot storage, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= val_reg;
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_read) rd_data <= mem[rd_addr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) rsp_valid <= 1'b0;
    else if (cmd.emit_single || cmd.emit_entry) rsp_valid <= 1'b1;
    else if (rsp_ready) rsp_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_single) begin
      rsp_status    <= cmd.emit_status;
      rsp_data      <= '0;
      rsp_hits      <= CNT_W'(hits);
      rsp_occupancy <= CNT_W'(fill_next);
      rsp_last      <= 1'b1;
    end else if (cmd.emit_entry) begin
      rsp_status    <= ST_OK;
      rsp_data      <= rd_data;
      rsp_hits      <= '0;
      rsp_occupancy <= CNT_W'(fill);
      rsp_last      <= scan_last;
    end
  end

endmodule

// ===== sv/bounded_array_deque.sv =====
// channel | dir | fields                                   | transaction when
// req     | in  | req_type, value                          | req.valid && req.ready
// rsp     | out | status, data, hits, occupancy, last      | rsp.valid && rsp.ready
//
// insert, delete, count: the request is registered, then the execute state loads the result
// register once it is free. search and read-all visit each entry in an address state and
// a data state, as the slot memory has a single registered read port; search ends in a done state.
// reset clears head and occupancy; slot contents are not cleared and need no pass.
// a stalled rsp holds the result; the next request is taken while it waits.
module bounded_array_deque import bdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  bdq_req_if.sink   req,
  bdq_rsp_if.source rsp
);

  bdq_cmd_t cmd;
  bdq_sts_t sts;
  logic     req_ready;

  assign req.ready = req_ready;

  // sequencer
  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // storage, pointers and result register
  bdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .req_type      (req.req_type),
    .req_value     (req.value),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_data      (rsp.data),
    .rsp_hits      (rsp.hits),
    .rsp_occupancy (rsp.occupancy),
    .rsp_last      (rsp.last),
    .cmd           (cmd),
    .sts           (sts)
  );

  // a result is loaded only when the output register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_single || cmd.emit_entry) |-> sts.out_free)
    else $error("result loaded over a pending result");

  // a new request is not taken right after a transaction
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> !req.ready)
    else $error("request taken while busy");

  // read-all only streams entries from a non-empty queue
  a_entry_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_entry |-> !sts.empty)
    else $error("entry streamed from empty queue");

endmodule
